>>> sv/shuffled_lcg_random_generator_unit_macros.svh
// Assertion macros for the checker file of the shuffled LCG generator.
`ifndef SHUFFLED_LCG_RANDOM_GENERATOR_UNIT_MACROS_SVH
`define SHUFFLED_LCG_RANDOM_GENERATOR_UNIT_MACROS_SVH

// Check a property at every rising edge outside of reset.
`define SLCG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Check a property at every rising edge, reset included.
`define SLCG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> sv/slcg_pkg.sv
// Types and constants shared by the shuffled LCG generator modules.
package slcg_pkg;

    // Generator word and result widths
    localparam int GEN_W = 32;
    localparam int VAL_W = 31;

    // Park-Miller multiplier and modulus 2^31-1
    localparam int MULT_W = 15;
    localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
    localparam logic [VAL_W-1:0]  LCG_MOD  = 31'h7FFF_FFFF;
    localparam int PROD_W = VAL_W + MULT_W;

    // Slot index: x / 6669205 == (x * ceil(2^54 / 6669205)) >> 54 for x < 2^31
    localparam int RECIP_W    = 32;
    localparam logic [RECIP_W-1:0] SLOT_RECIP = 32'd2701131321;
    localparam int SLOT_SHIFT = 54;
    localparam int DIVP_W     = VAL_W + RECIP_W;
    localparam int SLOT_Q_W   = DIVP_W - SLOT_SHIFT;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED,
        ST_DRAW_WR
    } t_state;

endpackage

>>> sv/slcg_lcg_step.sv
// One Park-Miller step: registered multiply by 16807, then reduction mod 2^31-1.
module slcg_lcg_step (
    input  logic                      i_clk,
    input  logic [slcg_pkg::VAL_W-1:0] i_operand,
    output logic [slcg_pkg::VAL_W-1:0] o_next
);
    import slcg_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [VAL_W:0]    fold_sum;

    // Register the product of the operand and the multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_operand) * PROD_W'(LCG_MULT);
    end

    // Fold the high part back in (2^31 == 1 mod M), then one conditional subtract
    always_comb begin
        fold_sum = (VAL_W+1)'(r_prod[PROD_W-1:VAL_W]) + (VAL_W+1)'(r_prod[VAL_W-1:0]);
        if (fold_sum >= (VAL_W+1)'(LCG_MOD)) begin
            o_next = VAL_W'(fold_sum - (VAL_W+1)'(LCG_MOD));
        end else begin
            o_next = fold_sum[VAL_W-1:0];
        end
    end

endmodule

>>> sv/shuffled_lcg_random_generator_unit.sv
// Top level of the shuffled Park-Miller random number generator.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------
//  input     | i_in_valid / o_in_stall | i_restart
//  output    | o_out_valid/ i_out_stall| o_random_value
//  config    | i_cfg_we                | i_cfg_wdata (seed)
//
// A steady draw is a shuffle table read then the write-back of the slot,
// with the next beat taken in the write-back cycle.
// A draw that must seed the table first runs the warm-up steps:
// each warm-up step is a multiply state and a reduce state in the single step unit.
// Reset is synchronous and active low; the table needs no clearing pass.
// A stalled output holds one result; the input is stalled while the write-back waits.
module shuffled_lcg_random_generator_unit #(
    parameter int TABLE_SIZE = 322
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic signed [slcg_pkg::GEN_W-1:0] i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [slcg_pkg::VAL_W-1:0]        o_random_value
);
    import slcg_pkg::*;

    localparam int WARMUP = TABLE_SIZE + 8;
    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(WARMUP);

    t_state r_state, n_state;

    logic [GEN_W-1:0]  r_seed;
    logic [GEN_W-1:0]  r_gen;
    logic [VAL_W-1:0]  r_last;
    logic [VAL_W-1:0]  r_x;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVP_W-1:0] r_divp;
    logic [IDX_W-1:0]  r_slot;
    logic [VAL_W-1:0]  r_rd;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_data;
    logic [VAL_W-1:0]  r_table [TABLE_SIZE];

    logic              take_ok;
    logic              seed_we;
    logic              draw_wr;
    logic              rd_en;
    logic              out_free;
    logic              accept;
    logic              at_entry;
    logic [VAL_W-1:0]  src_last;
    logic [GEN_W-1:0]  cur_gen;
    logic [VAL_W-1:0]  cur_last;
    logic [GEN_W-1:0]  neg_gen;
    logic              need_seed;
    logic [VAL_W-1:0]  seed_start;
    logic [VAL_W-1:0]  mul_a;
    logic [VAL_W-1:0]  div_a;
    logic [VAL_W-1:0]  step_y;
    logic [SLOT_Q_W-1:0] slot_q;
    logic [IDX_W-1:0]  slot_idx;

    // Generator step unit
    slcg_lcg_step u_step (
        .i_clk     (i_clk),
        .i_operand (mul_a),
        .o_next    (step_y)
    );

    // Sequencer outputs
    always_comb begin
        take_ok = 1'b0;
        seed_we = 1'b0;
        draw_wr = 1'b0;
        rd_en   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                take_ok = 1'b1;
            end
            ST_SEED_RED: begin
                seed_we = (r_cnt < CNT_W'(TABLE_SIZE));
            end
            ST_DRAW_RED: begin
                rd_en = 1'b1;
            end
            ST_DRAW_WR: begin
                take_ok = out_free;
                draw_wr = out_free;
            end
            default: begin
            end
        endcase
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign accept     = i_in_valid && take_ok;
    assign o_in_stall = !take_ok;
    assign at_entry   = (r_state == ST_IDLE) || (r_state == ST_DRAW_WR);

    // Forward the slot just read as the last output when a beat follows at once
    assign src_last  = (r_state == ST_DRAW_WR) ? r_rd : r_last;
    assign cur_gen   = i_restart ? r_seed : r_gen;
    assign cur_last  = i_restart ? '0 : src_last;
    assign need_seed = cur_gen[GEN_W-1] || (cur_gen == '0) || (cur_last == '0);
    assign neg_gen   = '0 - cur_gen;
    assign seed_start = (!neg_gen[GEN_W-1] && (neg_gen != '0)) ?
                        neg_gen[VAL_W-1:0] : VAL_W'(1);

    // Operand selection for the two multipliers
    assign mul_a = at_entry ? cur_gen[VAL_W-1:0] : r_x;
    assign div_a = at_entry ? cur_last : r_last;

    // Slot index from the reciprocal product, clamped to the last slot
    assign slot_q = r_divp[DIVP_W-1:SLOT_SHIFT];
    always_comb begin
        if (int'(slot_q) >= TABLE_SIZE) begin
            slot_idx = IDX_W'(TABLE_SIZE - 1);
        end else begin
            slot_idx = IDX_W'(slot_q);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = need_seed ? ST_SEED_MUL : ST_DRAW_RED;
                end
            end
            ST_SEED_MUL: begin
                n_state = ST_SEED_RED;
            end
            ST_SEED_RED: begin
                n_state = (r_cnt == '0) ? ST_DRAW_MUL : ST_SEED_MUL;
            end
            ST_DRAW_MUL: begin
                n_state = ST_DRAW_RED;
            end
            ST_DRAW_RED: begin
                n_state = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                if (out_free) begin
                    if (accept) begin
                        n_state = need_seed ? ST_SEED_MUL : ST_DRAW_RED;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, seed register and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seed  <= '0;
            r_gen   <= '0;
            r_last  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            priority if (accept) begin
                r_gen  <= cur_gen;
                r_last <= cur_last;
                r_cnt  <= CNT_W'(WARMUP - 1);
            end else if (r_state == ST_SEED_RED) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_gen  <= GEN_W'(step_y);
                    r_last <= step_y;
                end
            end else if (r_state == ST_DRAW_RED) begin
                r_gen <= GEN_W'(step_y);
            end else if (draw_wr) begin
                r_last <= r_rd;
            end else begin
                // hold
            end
        end
    end

    // Step operand and divide product
    always_ff @(posedge i_clk) begin
        r_divp <= DIVP_W'(div_a) * DIVP_W'(SLOT_RECIP);
        if (accept) begin
            r_x <= seed_start;
        end else if (r_state == ST_SEED_RED) begin
            r_x <= step_y;
        end
        if (r_state == ST_DRAW_RED) begin
            r_slot <= slot_idx;
        end
    end

    // Shuffle table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (seed_we) begin
            r_table[r_cnt[IDX_W-1:0]] <= step_y;
        end else if (draw_wr) begin
            r_table[r_slot] <= r_gen[VAL_W-1:0];
        end
        if (rd_en) begin
            r_rd <= r_table[slot_idx];
        end
    end

    // Output register: load on write-back, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (draw_wr) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (draw_wr) begin
            r_out_data <= r_rd;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_data;

endmodule

>>> sv/slcg_checker.sv
// Port-level checks for the shuffled LCG generator, bound to its top level.
`include "shuffled_lcg_random_generator_unit_macros.svh"

module slcg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [slcg_pkg::VAL_W-1:0]  o_random_value
);
    import slcg_pkg::*;

    // Hold a stalled result beat
    `SLCG_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_random_value), "stalled result beat changed")

    // Results are reduced mod 2^31-1 and never equal the modulus
    `SLCG_ASSERT(a_out_range, i_clk, i_rst_n, o_out_valid |-> (o_random_value != LCG_MOD), "result equals the modulus")

    // Stall the input in the cycle right after an input beat
    `SLCG_ASSERT(a_in_gap, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input beat taken in the cycle after another")

    // Leave reset ready for input with no result pending
    `SLCG_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "bad state after reset")

endmodule

bind shuffled_lcg_random_generator_unit slcg_checker u_slcg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_random_value (o_random_value)
);

>>> sim/testbench.sv
// Self-checking testbench for the shuffled Park-Miller random number generator.
module testbench;
    import slcg_pkg::*;

    localparam int     TABLE_DEPTH    = 322;
    localparam int     WARMUP_STEPS   = TABLE_DEPTH + 8;
    localparam longint MINSTD_MULT    = 16807;
    localparam longint MINSTD_MOD     = 64'h7FFF_FFFF;
    localparam longint MINSTD_QUOT    = 64'h1_F31D;
    localparam int     SLOT_DIVISOR   = 6669205;
    localparam int     WATCHDOG_LIMIT = 8000;
    localparam int     RANDOM_PHASES  = 5;
    localparam int     PHASE_DRAWS    = 170;
    localparam int     HOLD_TRIGGER   = 60;
    localparam int     LONG_HOLD      = 300;
    localparam logic   DRAW_RESTART   = 1'b1;
    localparam logic   DRAW_CONTINUE  = 1'b0;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic signed [GEN_W-1:0] i_cfg_wdata    = '0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_stall;
    logic                    i_restart      = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall    = 1'b0;
    logic [VAL_W-1:0]        o_random_value;

    // Generator copy kept by the testbench
    logic [GEN_W-1:0] seed_reg = '0;
    logic [GEN_W-1:0] gen_word = '0;
    logic [VAL_W-1:0] last_out = '0;
    logic [VAL_W-1:0] shuffle_tab [TABLE_DEPTH] = '{default: '0};

    logic             draw_requests [$];
    logic [VAL_W-1:0] predicted_draws [$];
    logic [VAL_W-1:0] want_value;

    int  send_gap      = 0;
    int  stall_gap     = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;
    bit  quiet         = 1'b0;
    int  idle_cycles   = 0;
    int  mismatch_count = 0;
    int  draws_checked = 0;
    int  draws_sent    = 0;
    int  reseed_count  = 0;
    int  seeds_loaded  = 0;

    shuffled_lcg_random_generator_unit #(
        .TABLE_SIZE(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // One minimal-standard step, Schrage form, on a word in 0..2^31-1
    function automatic longint minstd_advance(input longint x);
        longint r;
        r = MINSTD_MULT * x - MINSTD_MOD * (x / MINSTD_QUOT);
        if (r < 0) r += MINSTD_MOD;
        return r;
    endfunction

    // Predict one draw and update the generator copy
    function automatic logic [VAL_W-1:0] draw_number(input logic restart);
        logic [GEN_W-1:0] neg;
        longint           s;
        int               slot;
        logic [VAL_W-1:0] picked;
        if (restart) begin
            gen_word = seed_reg;
            last_out = '0;
        end
        // Refill the table when the generator is spent or nothing was drawn yet
        if ($signed(gen_word) <= 0 || last_out == 0) begin
            neg = -gen_word;
            s = ($signed(neg) >= 1) ? longint'(neg) : 1;
            for (int i = WARMUP_STEPS - 1; i >= 0; i--) begin
                s = minstd_advance(s);
                if (i < TABLE_DEPTH) shuffle_tab[i] = s[VAL_W-1:0];
            end
            gen_word = s[GEN_W-1:0];
            last_out = shuffle_tab[0];
            reseed_count++;
        end
        gen_word = GEN_W'(minstd_advance(longint'(gen_word[VAL_W-1:0])));
        slot = last_out / SLOT_DIVISOR;
        if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
        picked = shuffle_tab[slot];
        last_out = picked;
        shuffle_tab[slot] = gen_word[VAL_W-1:0];
        return picked;
    endfunction

    // Request driver: predict on each accepted beat, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_draws.push_back(draw_number(i_restart));
                draws_sent <= draws_sent + 1;
            end
            if (i_in_valid && o_in_stall) begin
                // hold the stalled beat
            end else if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (draw_requests.size() != 0 && !quiet && $urandom_range(0, 15) == 0) begin
                send_gap   <= $urandom_range(0, 12);
                i_in_valid <= 1'b0;
            end else if (draw_requests.size() != 0) begin
                i_in_valid <= 1'b1;
                i_restart  <= draw_requests.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && draws_checked >= HOLD_TRIGGER) begin
            hold_done   <= 1'b1;
            hold_left   <= LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap   <= stall_gap - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_gap   <= $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result monitor: compare each beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_draws.size() == 0) begin
                $error("random_value beat %0d arrived with no draw pending", o_random_value);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want_value = predicted_draws.pop_front();
                if (o_random_value !== want_value) begin
                    $error("random_value mismatch: expected %0d, actual %0d",
                           want_value, o_random_value);
                    mismatch_count <= mismatch_count + 1;
                end
                draws_checked <= draws_checked + 1;
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Write the seed register while the block is idle
    task automatic load_seed(input logic [GEN_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        seed_reg = value;
        seeds_loaded++;
        @(negedge i_clk);
    endtask

    // Wait until every request went out and every result came back
    task automatic wait_drained();
        while (draw_requests.size() != 0 || i_in_valid || predicted_draws.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Load a seed, restart from it, then mostly plain draws
    task automatic run_phase(input logic [GEN_W-1:0] seed, input int count);
        load_seed(seed);
        draw_requests.push_back(DRAW_RESTART);
        for (int i = 1; i < count; i++)
            draw_requests.push_back(($urandom_range(0, 39) == 0) ? DRAW_RESTART : DRAW_CONTINUE);
        wait_drained();
    endtask

    initial begin
        logic [GEN_W-1:0] seed;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Draw from reset state (seed 0), then restart on the reset seed
        draw_requests.push_back(DRAW_CONTINUE);
        draw_requests.push_back(DRAW_CONTINUE);
        draw_requests.push_back(DRAW_RESTART);
        wait_drained();

        // Largest positive seed: negation falls below one
        load_seed(32'h7FFF_FFFF);
        draw_requests.push_back(DRAW_RESTART);
        draw_requests.push_back(DRAW_CONTINUE);
        wait_drained();

        // Most negative seed wraps onto itself
        load_seed(32'h8000_0000);
        draw_requests.push_back(DRAW_RESTART);
        draw_requests.push_back(DRAW_CONTINUE);
        wait_drained();

        // Minus the modulus: table of zeros, then a forced reseed
        load_seed(32'h8000_0001);
        draw_requests.push_back(DRAW_RESTART);
        draw_requests.push_back(DRAW_CONTINUE);
        draw_requests.push_back(DRAW_CONTINUE);
        wait_drained();

        // Minus one
        load_seed(32'hFFFF_FFFF);
        draw_requests.push_back(DRAW_RESTART);
        draw_requests.push_back(DRAW_CONTINUE);
        wait_drained();

        // Minus two, restart twice on it
        load_seed(32'hFFFF_FFFE);
        draw_requests.push_back(DRAW_RESTART);
        draw_requests.push_back(DRAW_CONTINUE);
        draw_requests.push_back(DRAW_RESTART);
        wait_drained();

        // Largest seed that survives the step
        load_seed(32'h8000_0002);
        draw_requests.push_back(DRAW_RESTART);
        draw_requests.push_back(DRAW_CONTINUE);
        draw_requests.push_back(DRAW_CONTINUE);
        wait_drained();

        // Smallest positive seed
        load_seed(32'h0000_0001);
        draw_requests.push_back(DRAW_RESTART);
        draw_requests.push_back(DRAW_CONTINUE);
        wait_drained();

        // Long random sequences, mostly from negative seeds; no idling in the last one
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            seed = $urandom;
            if ($urandom_range(0, 3) != 0) seed[GEN_W-1] = 1'b1;
            if (p == RANDOM_PHASES - 1) quiet = 1'b1;
            run_phase(seed, PHASE_DRAWS);
        end

        repeat (20) @(negedge i_clk);
        if (predicted_draws.size() != 0)
            $error("%0d random_value beats never arrived", predicted_draws.size());
        $display("Checked %0d of %0d draws over %0d seed loads; %0d draws refilled the table.",
                 draws_checked, draws_sent, seeds_loaded, reseed_count);
        if (mismatch_count == 0 && predicted_draws.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> shuffled_lcg_random_generator_unit.f
+incdir+sv
sv/slcg_pkg.sv
sv/slcg_lcg_step.sv
sv/shuffled_lcg_random_generator_unit.sv
sv/slcg_checker.sv
sim/testbench.sv
